FILE: rtl/m3i_pkg.sv
// Package for the 3x3 fixed-point matrix inverse: shared constants, the
// cofactor index table and the queue status type. No dependencies.
package m3i_pkg;

    localparam int unsigned DATA_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF  = 16;
    localparam int unsigned N_ELEM         = 9;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned FRONT_STAGES   = 7;

    // Each cofactor is elem[a]*elem[b] - elem[c]*elem[d].
    localparam int unsigned COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // Cofactors used for the first-row expansion of the determinant.
    localparam int unsigned DET_COF [3] = '{0, 3, 6};

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Width of one queue entry: singular, |det|, quotient signs, |cofactors|.
    function automatic int unsigned q_width(input int unsigned w);
        return 1 + (3 * w + 2) + N_ELEM + N_ELEM * (2 * w + 1);
    endfunction

endpackage

FILE: rtl/matrix3_inverse.sv
// Top level of the 3x3 signed fixed-point matrix inverse.
// Depends on m3i_pkg, m3i_front, m3i_queue and m3i_back.
//
//   Channel   Handshake             Payload
//   input     start / busy          elem_0 .. elem_8
//   result    done (one cycle)      inv_0 .. inv_8, singular
//
// One matrix is accepted per cycle while busy is low. Each result passes
// through seven front stages (products, cofactors, the split determinant
// multiply and signs), the queue, a divider set-up stage, DATA_WIDTH - 1
// divider stages and the output register. Reset clears all valid bits;
// busy rises only if the queue fills, and since the receiver cannot stall
// it stays low.
module matrix3_inverse #(
    parameter int unsigned DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [DATA_WIDTH-1:0]    elem_0,
    input  logic signed [DATA_WIDTH-1:0]    elem_1,
    input  logic signed [DATA_WIDTH-1:0]    elem_2,
    input  logic signed [DATA_WIDTH-1:0]    elem_3,
    input  logic signed [DATA_WIDTH-1:0]    elem_4,
    input  logic signed [DATA_WIDTH-1:0]    elem_5,
    input  logic signed [DATA_WIDTH-1:0]    elem_6,
    input  logic signed [DATA_WIDTH-1:0]    elem_7,
    input  logic signed [DATA_WIDTH-1:0]    elem_8,
    output logic                            done,
    output logic signed [DATA_WIDTH-1:0]    inv_0,
    output logic signed [DATA_WIDTH-1:0]    inv_1,
    output logic signed [DATA_WIDTH-1:0]    inv_2,
    output logic signed [DATA_WIDTH-1:0]    inv_3,
    output logic signed [DATA_WIDTH-1:0]    inv_4,
    output logic signed [DATA_WIDTH-1:0]    inv_5,
    output logic signed [DATA_WIDTH-1:0]    inv_6,
    output logic signed [DATA_WIDTH-1:0]    inv_7,
    output logic signed [DATA_WIDTH-1:0]    inv_8,
    output logic                            singular
);
    import m3i_pkg::*;

    localparam int unsigned QW = q_width(DATA_WIDTH);

    logic [N_ELEM-1:0][DATA_WIDTH-1:0]  elem;
    logic [N_ELEM-1:0][DATA_WIDTH-1:0]  inv;
    logic                               accept;
    logic                               front_valid;
    logic [QW-1:0]                      front_data;
    logic [QW-1:0]                      back_data;
    logic                               back_valid;
    q_status_t                          q_status;

    assign elem   = {elem_8, elem_7, elem_6, elem_5, elem_4, elem_3, elem_2, elem_1, elem_0};
    assign accept = start && !busy;
    assign busy   = q_status.full;

    m3i_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .elem      (elem),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    m3i_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_data),
        .pop       (back_valid),
        .pop_data  (back_data),
        .status    (q_status)
    );

    assign back_valid = !q_status.empty;

    m3i_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (back_valid),
        .in_data  (back_data),
        .done     (done),
        .singular (singular),
        .inv      (inv)
    );

    assign inv_0 = inv[0];
    assign inv_1 = inv[1];
    assign inv_2 = inv[2];
    assign inv_3 = inv[3];
    assign inv_4 = inv[4];
    assign inv_5 = inv[5];
    assign inv_6 = inv[6];
    assign inv_7 = inv[7];
    assign inv_8 = inv[8];

endmodule

FILE: rtl/m3i_front.sv
// Front part of the matrix inverse: cofactors, determinant and signs.
// Depends on m3i_pkg.
module m3i_front #(
    parameter int unsigned DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    input  logic [m3i_pkg::N_ELEM-1:0][DATA_WIDTH-1:0]      elem,
    output logic                                            out_valid,
    output logic [m3i_pkg::q_width(DATA_WIDTH)-1:0]         out_data
);
    import m3i_pkg::*;

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned CW = 2 * W + 1;
    localparam int unsigned DW = 3 * W + 2;

    logic [FRONT_STAGES-1:0]    vld_reg;
    logic signed [W-1:0]        m_reg    [N_ELEM];
    logic signed [2*W-1:0]      pa_reg   [N_ELEM];
    logic signed [2*W-1:0]      pb_reg   [N_ELEM];
    logic signed [W-1:0]        mc1_reg  [3];
    logic signed [W-1:0]        mc2_reg  [3];
    logic signed [CW-1:0]       cof_reg  [N_ELEM];
    logic signed [CW-1:0]       cof3_reg [N_ELEM];
    logic signed [CW-1:0]       cof4_reg [N_ELEM];
    logic signed [CW-1:0]       cof5_reg [N_ELEM];
    logic signed [2*W:0]        plo_reg  [3];
    logic signed [2*W:0]        phi_reg  [3];
    logic signed [DW-1:0]       t_reg    [3];
    logic signed [DW-1:0]       det_reg;
    logic [DW-1:0]              dmag;
    logic [N_ELEM-1:0]          neg;
    logic [N_ELEM-1:0][CW-1:0]  mag;
    logic [q_width(W)-1:0]      out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_ELEM; i++)
        begin
            m_reg[i]    <= elem[i];
            cof3_reg[i] <= cof_reg[i];
            cof4_reg[i] <= cof3_reg[i];
            cof5_reg[i] <= cof4_reg[i];
        end
        for (int j = 0; j < 3; j++)
        begin
            mc1_reg[j] <= m_reg[j];
            mc2_reg[j] <= mc1_reg[j];
            plo_reg[j] <= mc2_reg[j] * $signed({1'b0, cof_reg[DET_COF[j]][W-1:0]});
            phi_reg[j] <= mc2_reg[j] * $signed(cof_reg[DET_COF[j]][CW-1:W]);
            t_reg[j]   <= (DW'(phi_reg[j]) <<< W) + DW'(plo_reg[j]);
        end
        det_reg      <= t_reg[0] + t_reg[1] + t_reg[2];
        out_data_reg <= {(det_reg == '0), dmag, neg, mag};
    end

    for (genvar i = 0; i < N_ELEM; i++)
    begin : g_cof
        always_ff @(posedge clk)
        begin
            pa_reg[i]  <= m_reg[COF_IDX[i][0]] * m_reg[COF_IDX[i][1]];
            pb_reg[i]  <= m_reg[COF_IDX[i][2]] * m_reg[COF_IDX[i][3]];
            cof_reg[i] <= pa_reg[i] - pb_reg[i];
        end
    end

    always_comb
    begin
        dmag = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        for (int i = 0; i < N_ELEM; i++)
        begin
            mag[i] = cof5_reg[i][CW-1] ? CW'(-cof5_reg[i]) : CW'(cof5_reg[i]);
            neg[i] = cof5_reg[i][CW-1] ^ det_reg[DW-1];
        end
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/m3i_queue.sv
// Short queue that decouples the front and back parts of the inverse.
// Depends on m3i_pkg for the status type.
module m3i_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = m3i_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output m3i_pkg::q_status_t  status
);
    import m3i_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [CNW-1:0]     count_reg;
    logic               do_push;
    logic               do_pop;

    assign do_push = push && (count_reg != CNW'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNW'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

FILE: rtl/m3i_back.sv
// Back part of the matrix inverse: nine pipelined restoring dividers with
// saturation and the singular case. Depends on m3i_pkg.
module m3i_back #(
    parameter int unsigned DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic [m3i_pkg::q_width(DATA_WIDTH)-1:0]     in_data,
    output logic                                        done,
    output logic                                        singular,
    output logic [m3i_pkg::N_ELEM-1:0][DATA_WIDTH-1:0]  inv
);
    import m3i_pkg::*;

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned CW = 2 * W + 1;
    localparam int unsigned DW = 3 * W + 2;
    localparam int unsigned NW = CW + 2 * FRAC_BITS;
    localparam int unsigned RW = (NW > DW + W) ? NW : DW + W;

    logic                       in_sing;
    logic [DW-1:0]              in_dmag;
    logic [N_ELEM-1:0]          in_neg;
    logic [N_ELEM-1:0][CW-1:0]  in_mag;

    logic [W-1:0]               vld_reg;
    logic [W-1:0]               sing_reg;
    logic [DW-1:0]              dmag_reg [W];
    logic [N_ELEM-1:0]          neg_reg  [W];
    logic [N_ELEM-1:0]          big_reg  [W];
    logic [RW-1:0]              rem_reg  [W][N_ELEM];
    logic [W-1:0]               q_reg    [W][N_ELEM];

    logic                       done_reg;
    logic                       singular_reg;
    logic [N_ELEM-1:0][W-1:0]   inv_reg;

    assign {in_sing, in_dmag, in_neg, in_mag} = in_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[W-2:0], in_valid};
            done_reg <= vld_reg[W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sing_reg[0] <= in_sing;
        dmag_reg[0] <= in_dmag;
        neg_reg[0]  <= in_neg;
        for (int i = 0; i < N_ELEM; i++)
        begin
            rem_reg[0][i] <= RW'(in_mag[i]) << (2 * FRAC_BITS);
            q_reg[0][i]   <= '0;
            big_reg[0][i] <= (RW'(in_mag[i]) << (2 * FRAC_BITS))
                             >= (RW'(in_dmag) << (W - 1));
        end
    end

    for (genvar s = 1; s < W; s++)
    begin : g_stage
        localparam int unsigned K = W - 1 - s;
        logic [RW:0]    diff [N_ELEM];

        always_comb
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                diff[i] = {1'b0, rem_reg[s-1][i]} - {1'b0, RW'(dmag_reg[s-1]) << K};
            end
        end

        always_ff @(posedge clk)
        begin
            sing_reg[s] <= sing_reg[s-1];
            dmag_reg[s] <= dmag_reg[s-1];
            neg_reg[s]  <= neg_reg[s-1];
            big_reg[s]  <= big_reg[s-1];
            for (int i = 0; i < N_ELEM; i++)
            begin
                rem_reg[s][i] <= diff[i][RW] ? rem_reg[s-1][i] : diff[i][RW-1:0];
                q_reg[s][i]   <= q_reg[s-1][i] | (W'(!diff[i][RW]) << K);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        singular_reg <= vld_reg[W-1] && sing_reg[W-1];
        for (int i = 0; i < N_ELEM; i++)
        begin
            if (sing_reg[W-1])
            begin
                inv_reg[i] <= '0;
            end
            else if (big_reg[W-1][i])
            begin
                inv_reg[i] <= neg_reg[W-1][i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                inv_reg[i] <= neg_reg[W-1][i] ? -q_reg[W-1][i] : q_reg[W-1][i];
            end
        end
    end

    assign done     = done_reg;
    assign singular = singular_reg;
    assign inv      = inv_reg;

endmodule

FILE: rtl/m3i_checker.sv
// Port-level checks for matrix3_inverse, attached by a bind statement.
// Depends on m3i_pkg and the top level's ports.
module m3i_checker #(
    parameter int unsigned DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [DATA_WIDTH-1:0]    elem_0,
    input logic [DATA_WIDTH-1:0]    elem_1,
    input logic [DATA_WIDTH-1:0]    elem_2,
    input logic [DATA_WIDTH-1:0]    elem_3,
    input logic [DATA_WIDTH-1:0]    elem_4,
    input logic [DATA_WIDTH-1:0]    elem_5,
    input logic [DATA_WIDTH-1:0]    elem_6,
    input logic [DATA_WIDTH-1:0]    elem_7,
    input logic [DATA_WIDTH-1:0]    elem_8,
    input logic                     done,
    input logic [DATA_WIDTH-1:0]    inv_0,
    input logic [DATA_WIDTH-1:0]    inv_1,
    input logic [DATA_WIDTH-1:0]    inv_2,
    input logic [DATA_WIDTH-1:0]    inv_3,
    input logic [DATA_WIDTH-1:0]    inv_4,
    input logic [DATA_WIDTH-1:0]    inv_5,
    input logic [DATA_WIDTH-1:0]    inv_6,
    input logic [DATA_WIDTH-1:0]    inv_7,
    input logic [DATA_WIDTH-1:0]    inv_8,
    input logic                     singular
);
    import m3i_pkg::*;

    localparam int unsigned LATENCY = FRONT_STAGES + 2 + DATA_WIDTH;

    logic zero_in;

    assign zero_in = (elem_0 == '0) && (elem_1 == '0) && (elem_2 == '0)
                  && (elem_3 == '0) && (elem_4 == '0) && (elem_5 == '0)
                  && (elem_6 == '0) && (elem_7 == '0) && (elem_8 == '0);

    // Every transfer produces its result after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after a transfer");

    // A singular result carries all-zero entries.
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> ((inv_0 == '0) && (inv_1 == '0) && (inv_2 == '0)
            && (inv_3 == '0) && (inv_4 == '0) && (inv_5 == '0)
            && (inv_6 == '0) && (inv_7 == '0) && (inv_8 == '0)))
        else $error("singular result with nonzero entries");

    // The all-zero matrix is reported as singular.
    a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && zero_in) |-> ##LATENCY (done && singular))
        else $error("zero matrix not flagged singular");

    // The singular flag is shown only together with the strobe.
    a_sing_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        singular |-> done)
        else $error("singular flag without a result");

endmodule

bind matrix3_inverse m3i_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_m3i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .elem_0   (elem_0),
    .elem_1   (elem_1),
    .elem_2   (elem_2),
    .elem_3   (elem_3),
    .elem_4   (elem_4),
    .elem_5   (elem_5),
    .elem_6   (elem_6),
    .elem_7   (elem_7),
    .elem_8   (elem_8),
    .done     (done),
    .inv_0    (inv_0),
    .inv_1    (inv_1),
    .inv_2    (inv_2),
    .inv_3    (inv_3),
    .inv_4    (inv_4),
    .inv_5    (inv_5),
    .inv_6    (inv_6),
    .inv_7    (inv_7),
    .inv_8    (inv_8),
    .singular (singular)
);

FILE: tb/tb_matrix3_inverse.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
// Predicts each inverse with exact wide arithmetic and compares it per entry.
// Depends on m3i_pkg and matrix3_inverse.
module tb_matrix3_inverse;

    import m3i_pkg::*;

    localparam int DW      = DATA_WIDTH_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int LATENCY = DW + 9;
    localparam int LIMIT   = 2000;

    typedef logic signed [DW-1:0] elem_t;
    typedef elem_t                matrix_t [N_ELEM];

    typedef struct {
        matrix_t inv;
        logic    singular;
    } inverse_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    done;
    elem_t   elem [N_ELEM];
    elem_t   inv  [N_ELEM];
    logic    singular;

    inverse_t inverse_queue [$];
    int       error_count;
    int       sent_count;
    int       checked_count;
    int       singular_count;
    int       saturated_count;
    int       idle_cycles;

    matrix3_inverse dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .elem_0   (elem[0]),
        .elem_1   (elem[1]),
        .elem_2   (elem[2]),
        .elem_3   (elem[3]),
        .elem_4   (elem[4]),
        .elem_5   (elem[5]),
        .elem_6   (elem[6]),
        .elem_7   (elem[7]),
        .elem_8   (elem[8]),
        .done     (done),
        .inv_0    (inv[0]),
        .inv_1    (inv[1]),
        .inv_2    (inv[2]),
        .inv_3    (inv[3]),
        .inv_4    (inv[4]),
        .inv_5    (inv[5]),
        .inv_6    (inv[6]),
        .inv_7    (inv[7]),
        .inv_8    (inv[8]),
        .singular (singular)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic inverse_t invert(input matrix_t m);
        logic signed [127:0] cof [N_ELEM];
        logic signed [127:0] det;
        logic signed [255:0] num;
        logic signed [255:0] quot;
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        inverse_t r;
        hi = (256'sd1 <<< (DW - 1)) - 1;
        lo = -(256'sd1 <<< (DW - 1));
        for (int i = 0; i < N_ELEM; i++)
        begin
            cof[i] = 128'(m[COF_IDX[i][0]]) * 128'(m[COF_IDX[i][1]])
                   - 128'(m[COF_IDX[i][2]]) * 128'(m[COF_IDX[i][3]]);
        end
        det = 128'(m[0]) * cof[0] + 128'(m[1]) * cof[3] + 128'(m[2]) * cof[6];
        r.singular = (det == 0);
        for (int i = 0; i < N_ELEM; i++)
        begin
            if (r.singular)
            begin
                r.inv[i] = '0;
            end
            else
            begin
                num  = 256'(cof[i]) <<< (2 * FB);
                quot = num / 256'(det);
                if (quot > hi)
                    quot = hi;
                else if (quot < lo)
                    quot = lo;
                r.inv[i] = quot[DW-1:0];
            end
        end
        return r;
    endfunction

    // The start line stays high after a transfer; the next call either
    // drives a new matrix at once or lowers it for the idle gap.
    task automatic send_matrix(input matrix_t m);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        foreach (m[i]) elem[i] <= m[i];
        @(posedge clk);
        while (busy) @(posedge clk);
        inverse_queue.push_back(invert(m));
        sent_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            idle_cycles <= 0;
        else if (rst_n && done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        inverse_t want;
        if (rst_n && done)
        begin
            checked_count++;
            if (inverse_queue.size() == 0)
            begin
                $error("result transfer with no matrix outstanding");
                error_count++;
            end
            else
            begin
                want = inverse_queue.pop_front();
                if (singular !== want.singular)
                begin
                    $error("singular: expected %0b, got %0b", want.singular, singular);
                    error_count++;
                end
                for (int i = 0; i < N_ELEM; i++)
                begin
                    if (inv[i] !== want.inv[i])
                    begin
                        $error("inv_%0d: expected %0d, got %0d", i, want.inv[i], inv[i]);
                        error_count++;
                    end
                end
                if (want.singular)
                    singular_count++;
                foreach (want.inv[i])
                    if (want.inv[i] == {1'b0, {(DW-1){1'b1}}}
                        || want.inv[i] == {1'b1, {(DW-1){1'b0}}})
                        saturated_count++;
            end
        end
    end

    function automatic elem_t random_elem(input int mode);
        case (mode)
            0:       return elem_t'($urandom);
            1:       return elem_t'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            2:       return elem_t'($signed($urandom_range(0, 16)) - 8) <<< FB;
            default: return elem_t'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        while (inverse_queue.size() != 0) @(posedge clk);
    endtask

    task automatic test_identity_and_scaled();
        matrix_t m;
        for (int k = 0; k < 4; k++)
        begin
            foreach (m[i]) m[i] = '0;
            m[0] = elem_t'(1 <<< (FB + k));
            m[4] = elem_t'(-(1 <<< FB));
            m[8] = elem_t'(1 <<< (FB - k));
            send_matrix(m);
        end
    endtask

    task automatic test_singular();
        matrix_t m;
        foreach (m[i]) m[i] = '0;
        send_matrix(m);
        foreach (m[i]) m[i] = elem_t'(i + 1) <<< FB;
        send_matrix(m);
        foreach (m[i]) m[i] = random_elem(0);
        m[3] = m[0];
        m[4] = m[1];
        m[5] = m[2];
        send_matrix(m);
    endtask

    task automatic test_extremes();
        matrix_t m;
        foreach (m[i]) m[i] = {1'b1, {(DW-1){1'b0}}};
        send_matrix(m);
        foreach (m[i]) m[i] = '0;
        m[0] = {1'b1, {(DW-1){1'b0}}};
        m[4] = {1'b0, {(DW-1){1'b1}}};
        m[8] = {1'b1, {(DW-1){1'b0}}};
        send_matrix(m);
        m[0] = 1;
        m[4] = -1;
        m[8] = 1;
        send_matrix(m);
        foreach (m[i]) m[i] = '1;
        m[0] = {1'b0, {(DW-1){1'b1}}};
        send_matrix(m);
        foreach (m[i]) m[i] = (i % 2) ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
        m[4] = 0;
        send_matrix(m);
    endtask

    task automatic test_random(input int count);
        matrix_t m;
        int      mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 3);
            foreach (m[i]) m[i] = random_elem($urandom_range(0, 4) == 0 ? 0 : mode);
            if ($urandom_range(0, 15) == 0)
                foreach (m[i]) if (i >= 6) m[i] = m[i-3];
            send_matrix(m);
            if (n == count / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        error_count     = 0;
        sent_count      = 0;
        checked_count   = 0;
        singular_count  = 0;
        saturated_count = 0;
        idle_cycles     = 0;
        rst_n           = 1'b0;
        start           = 1'b0;
        foreach (elem[i]) elem[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_and_scaled();
        test_singular();
        test_extremes();
        test_random(1100);
        wait_drained();
        repeat (LATENCY + 4) @(posedge clk);
        $display("Sent %0d matrices and checked %0d inverses,", sent_count, checked_count);
        $display("%0d of them singular, %0d saturated entries.", singular_count,
                 saturated_count);
        if (error_count == 0 && inverse_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/m3i_pkg.sv
rtl/m3i_front.sv
rtl/m3i_queue.sv
rtl/m3i_back.sv
rtl/matrix3_inverse.sv
rtl/m3i_checker.sv
tb/tb_matrix3_inverse.sv
